/* design/skit_pkg.sv */
// Package for the sorted key insert table: field widths, request and status codes,
// the sequencer state type and the control bundle broadcast to the cell chain.
// No dependencies.
package skit_pkg;

    localparam int KEY_W   = 44;
    localparam int YEAR_W  = 12;
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;
    localparam int STAT_W  = 2;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 72;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic              cmp_en;
        logic              shift_en;
        logic [KEY_W-1:0]  key;
        logic [YEAR_W-1:0] year;
    } t_cell_ctrl;

endpackage

/* design/skit_cell.sv */
// One storage cell of the sorted chain: holds one key and year and decides
// locally whether it takes the new record or its left neighbour's record.
// Depends on skit_pkg.
module skit_cell (
    input  logic                        i_clk,
    input  skit_pkg::t_cell_ctrl        i_ctrl,
    input  logic                        i_occ,
    input  logic                        i_left_take,
    input  logic [skit_pkg::KEY_W-1:0]  i_left_key,
    input  logic [skit_pkg::YEAR_W-1:0] i_left_year,
    output logic                        o_take,
    output logic [skit_pkg::KEY_W-1:0]  o_key,
    output logic [skit_pkg::YEAR_W-1:0] o_year
);

    logic                        r_take;
    logic [skit_pkg::KEY_W-1:0]  r_key;
    logic [skit_pkg::YEAR_W-1:0] r_year;

    // An empty cell, or one whose key is strictly greater, lies behind the insertion point.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp_en) begin
            r_take <= !i_occ || (r_key > i_ctrl.key);
        end
        if (i_ctrl.shift_en && r_take) begin
            if (i_left_take) begin
                r_key  <= i_left_key;
                r_year <= i_left_year;
            end else begin
                r_key  <= i_ctrl.key;
                r_year <= i_ctrl.year;
            end
        end
    end

    assign o_take = r_take;
    assign o_key  = r_key;
    assign o_year = r_year;

endmodule

/* design/sorted_key_insert_table_core.sv */
// Sorted key insert table: a chain of DEPTH cells kept in ascending key order.
// Each request passes through an accept state, the compare state in the cells, then the shift
// and encode state; a new request is accepted only after the previous one has been executed.
// A result waits in an output register, stalling the sequencer only if still unread.
// Synchronous active-low reset empties the table and clears the handshake state;
// the cells themselves are not cleared, entries beyond the count are never read.
module sorted_key_insert_table_core #(
    parameter int DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // entry_key [43:0], entry_year [55:44], read_index [61:56], zero fill [63:62]
    input  logic [skit_pkg::S_DATA_W-1:0]    i_s_tdata,
    // action [0]
    input  logic                             i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // out_key [43:0], out_year [55:44], position [61:56], entry_count [68:62],
    // status [70:69], zero fill [71]
    output logic [skit_pkg::M_DATA_W-1:0]    o_m_tdata
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    skit_pkg::t_state                r_state, n_state;
    logic                            r_act;
    logic [skit_pkg::KEY_W-1:0]      r_key;
    logic [skit_pkg::YEAR_W-1:0]     r_year;
    logic [skit_pkg::IDX_W-1:0]      r_idx;
    logic [CW-1:0]                   r_count, n_count;
    logic                            r_out_valid;
    logic [skit_pkg::M_DATA_W-1:0]   r_out_data, n_out_data;

    logic                            accept;
    logic                            cmp_en;
    logic                            go;
    logic                            full;
    logic                            ins_ok;
    skit_pkg::t_cell_ctrl            ctrl;

    logic [DEPTH-1:0]                occ;
    logic [DEPTH-1:0]                take;
    logic [DEPTH-1:0]                boundary;
    logic [DEPTH-1:0]                sel;
    logic [skit_pkg::KEY_W-1:0]      c_key  [DEPTH];
    logic [skit_pkg::YEAR_W-1:0]     c_year [DEPTH];

    logic [PW-1:0]                   pos;
    logic [PW+5:0]                   pos_ext;
    logic [CW+6:0]                   cnt_ext;
    logic [CW+5:0]                   idx_w;
    logic [CW+5:0]                   cnt_w;
    logic [skit_pkg::KEY_W-1:0]      rd_key;
    logic [skit_pkg::YEAR_W-1:0]     rd_year;

    assign accept = i_s_tvalid && o_s_tready;
    assign full   = (r_count == CW'(DEPTH));
    assign ins_ok = (r_act == skit_pkg::ACT_INSERT) && !full;

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            skit_pkg::ST_IDLE: begin
                if (i_s_tvalid) n_state = skit_pkg::ST_CMP;
            end
            skit_pkg::ST_CMP: begin
                n_state = skit_pkg::ST_EXEC;
            end
            skit_pkg::ST_EXEC: begin
                if (!r_out_valid || i_m_tready) n_state = skit_pkg::ST_IDLE;
            end
            default: begin
                n_state = skit_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_s_tready = 1'b0;
        cmp_en     = 1'b0;
        go         = 1'b0;
        case (r_state)
            skit_pkg::ST_IDLE: o_s_tready = 1'b1;
            skit_pkg::ST_CMP:  cmp_en     = 1'b1;
            skit_pkg::ST_EXEC: go         = !r_out_valid || i_m_tready;
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= skit_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (go) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act  <= i_s_tuser;
            r_key  <= i_s_tdata[skit_pkg::KEY_W-1:0];
            r_year <= i_s_tdata[skit_pkg::KEY_W +: skit_pkg::YEAR_W];
            r_idx  <= i_s_tdata[skit_pkg::KEY_W+skit_pkg::YEAR_W +: skit_pkg::IDX_W];
        end
        if (go) begin
            r_out_data <= n_out_data;
        end
    end

    assign ctrl.cmp_en   = cmp_en;
    assign ctrl.shift_en = go && ins_ok;
    assign ctrl.key      = r_key;
    assign ctrl.year     = r_year;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            assign occ[g] = (r_count > CW'(g));
            assign sel[g] = (idx_w == (CW+6)'(g));
            if (g == 0) begin : g_first
                assign boundary[g] = take[g];
                skit_cell u_cell (
                    .i_clk       (i_clk),
                    .i_ctrl      (ctrl),
                    .i_occ       (occ[g]),
                    .i_left_take (1'b0),
                    .i_left_key  ('0),
                    .i_left_year ('0),
                    .o_take      (take[g]),
                    .o_key       (c_key[g]),
                    .o_year      (c_year[g])
                );
            end else begin : g_next
                assign boundary[g] = take[g] && !take[g-1];
                skit_cell u_cell (
                    .i_clk       (i_clk),
                    .i_ctrl      (ctrl),
                    .i_occ       (occ[g]),
                    .i_left_take (take[g-1]),
                    .i_left_key  (c_key[g-1]),
                    .i_left_year (c_year[g-1]),
                    .o_take      (take[g]),
                    .o_key       (c_key[g]),
                    .o_year      (c_year[g])
                );
            end
        end
    endgenerate

    // The take flags form a run of zeros then ones, so the boundary is one-hot
    // and its index can be OR-encoded.
    always_comb begin
        pos     = '0;
        rd_key  = '0;
        rd_year = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (boundary[i]) pos = pos | PW'(i);
            if (sel[i]) begin
                rd_key  = rd_key | c_key[i];
                rd_year = rd_year | c_year[i];
            end
        end
    end

    assign idx_w = {{CW{1'b0}}, r_idx};
    assign cnt_w = {6'b0, r_count};

    always_comb begin
        n_count    = r_count;
        n_out_data = '0;
        pos_ext    = {6'b0, pos};
        cnt_ext    = '0;
        if (r_act == skit_pkg::ACT_INSERT) begin
            if (full) begin
                cnt_ext = {7'b0, r_count};
                n_out_data[70:69] = skit_pkg::STAT_FULL;
            end else begin
                if (go) n_count = r_count + CW'(1);
                cnt_ext = {7'b0, r_count + CW'(1)};
                n_out_data[61:56] = pos_ext[5:0];
                n_out_data[70:69] = skit_pkg::STAT_OK;
            end
        end else begin
            cnt_ext = {7'b0, r_count};
            n_out_data[61:56] = r_idx;
            if (idx_w >= cnt_w) begin
                n_out_data[70:69] = skit_pkg::STAT_RANGE;
            end else begin
                n_out_data[43:0]  = rd_key;
                n_out_data[55:44] = rd_year;
                n_out_data[70:69] = skit_pkg::STAT_OK;
            end
        end
        n_out_data[68:62] = cnt_ext[6:0];
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("stored count exceeds table depth");

    a_count_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && ins_ok) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("count did not advance after an insert");

    a_boundary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && ins_ok) |-> $onehot(boundary))
        else $error("insertion point is not unique");

    a_hold_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != skit_pkg::ST_EXEC) |=> $stable(r_count))
        else $error("count changed outside the execute cycle");

endmodule

/* dv/sorted_key_insert_table_core_tb.sv */
// Self-checking testbench for sorted_key_insert_table_core: random and directed insert and
// read requests, predicted by a behavioural copy of the sorted table and compared per field.
// Depends on skit_pkg and the core RTL only.
module sorted_key_insert_table_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_W    = skit_pkg::KEY_W;
    localparam int YEAR_W   = skit_pkg::YEAR_W;
    localparam int IDX_W    = skit_pkg::IDX_W;
    localparam int CNT_W    = skit_pkg::CNT_W;
    localparam int STAT_W   = skit_pkg::STAT_W;
    localparam int S_DATA_W = skit_pkg::S_DATA_W;
    localparam int M_DATA_W = skit_pkg::M_DATA_W;

    localparam int TBL_DEPTH = 64;
    localparam int N_RANDOM  = 1200;
    localparam logic [KEY_W-1:0] KEY_TOP  = 44'd9999999999999;
    localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};

    typedef struct packed {
        logic              act;
        logic [KEY_W-1:0]  key;
        logic [YEAR_W-1:0] year;
        logic [IDX_W-1:0]  idx;
        logic              hold;
        logic              no_gap;
    } t_req;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [YEAR_W-1:0] year;
        logic [IDX_W-1:0]  pos;
        logic [CNT_W-1:0]  cnt;
        logic [STAT_W-1:0] stat;
    } t_entry_result;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata  = '0;
    logic                i_s_tuser  = 1'b0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [M_DATA_W-1:0] o_m_tdata;

    t_req          pend_q[$];
    t_entry_result exp_q[$];

    // Behavioural copy of the sorted table
    logic [KEY_W-1:0]  row_key  [TBL_DEPTH];
    logic [YEAR_W-1:0] row_year [TBL_DEPTH];
    int                row_count = 0;

    logic [KEY_W-1:0] key_pool [8];
    int plan_cnt    = 0;
    int gap_left    = 0;
    int stall_left  = 0;
    int results_seen = 0;
    bit long_done   = 1'b0;
    int err_cnt     = 0;

    sorted_key_insert_table_core #(
        .DEPTH (TBL_DEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Mostly no gap, some short ones and the odd long one.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [KEY_W-1:0] draw_key();
        logic [63:0] raw;
        int          sel;
        raw = {$urandom(), $urandom()};
        sel = $urandom_range(0, 99);
        if (sel < 35)
            return key_pool[$urandom_range(0, 7)];
        if (sel < 40)
            return '0;
        if (sel < 45)
            return KEY_TOP;
        if (sel < 48)
            return KEY_ONES;
        if (sel < 75)
            return KEY_W'(raw % 64'd10000000000000);
        return raw[KEY_W-1:0];
    endfunction

    task automatic add_req(input logic act, input logic [KEY_W-1:0] key,
                           input logic [YEAR_W-1:0] year, input logic [IDX_W-1:0] idx,
                           input logic hold, input logic no_gap);
        t_req r;
        r.act    = act;
        r.key    = key;
        r.year   = year;
        r.idx    = idx;
        r.hold   = hold;
        r.no_gap = no_gap;
        if (act == skit_pkg::ACT_INSERT && plan_cnt < TBL_DEPTH)
            plan_cnt++;
        pend_q.push_back(r);
    endtask

    // Applies one accepted request to the table copy and queues the result it should give.
    task automatic apply_request(input t_req r);
        t_entry_result res;
        int            slot;
        int            k;
        res = '0;
        if (r.act == skit_pkg::ACT_INSERT) begin
            if (row_count >= TBL_DEPTH) begin
                res.stat = skit_pkg::STAT_FULL;
                res.cnt  = CNT_W'(row_count);
            end else begin
                slot = 0;
                // Equal keys stay in arrival order, so the new record goes after them.
                while (slot < row_count && row_key[slot] <= r.key)
                    slot++;
                for (k = row_count; k > slot; k--) begin
                    row_key[k]  = row_key[k-1];
                    row_year[k] = row_year[k-1];
                end
                row_key[slot]  = r.key;
                row_year[slot] = r.year;
                row_count++;
                res.pos  = IDX_W'(slot);
                res.cnt  = CNT_W'(row_count);
                res.stat = skit_pkg::STAT_OK;
            end
        end else begin
            res.pos = r.idx;
            res.cnt = CNT_W'(row_count);
            if (int'(r.idx) >= row_count) begin
                res.stat = skit_pkg::STAT_RANGE;
            end else begin
                res.key  = row_key[r.idx];
                res.year = row_year[r.idx];
                res.stat = skit_pkg::STAT_OK;
            end
        end
        exp_q.push_back(res);
    endtask

    task automatic report_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
        err_cnt++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
    endtask

    // Driver: presents queued requests, holding each until it is taken.
    always @(posedge i_clk) begin : drv
        logic take;
        logic go;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            take = i_s_tvalid && o_s_tready;
            go   = 1'b0;
            if (take) begin
                apply_request(pend_q[0]);
                gap_left = pend_q[0].no_gap ? 0 : draw_gap();
                void'(pend_q.pop_front());
            end
            if (take || !i_s_tvalid) begin
                if (gap_left > 0)
                    gap_left--;
                else if (pend_q.size() != 0 && !(pend_q[0].hold && exp_q.size() != 0))
                    go = 1'b1;
                i_s_tvalid <= go;
                if (go) begin
                    i_s_tdata <= {2'b00, pend_q[0].idx, pend_q[0].year, pend_q[0].key};
                    i_s_tuser <= pend_q[0].act;
                end
            end
        end
    end

    // Monitor: checks each result against the oldest expectation and drives the ready.
    always @(posedge i_clk) begin : mon
        t_entry_result want;
        t_entry_result got;
        logic          rdy;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got = {o_m_tdata[43:0], o_m_tdata[55:44], o_m_tdata[61:56],
                       o_m_tdata[68:62], o_m_tdata[70:69]};
                results_seen++;
                if (exp_q.size() == 0) begin
                    report_field("unexpected result", '0, o_m_tdata[63:0]);
                end else begin
                    want = exp_q.pop_front();
                    if (got.key !== want.key)
                        report_field("out_key", 64'(want.key), 64'(got.key));
                    if (got.year !== want.year)
                        report_field("out_year", 64'(want.year), 64'(got.year));
                    if (got.pos !== want.pos)
                        report_field("position", 64'(want.pos), 64'(got.pos));
                    if (got.cnt !== want.cnt)
                        report_field("entry_count", 64'(want.cnt), 64'(got.cnt));
                    if (got.stat !== want.stat)
                        report_field("status", 64'(want.stat), 64'(got.stat));
                end
            end
            // One long hold-off so that the core fills up and stalls its input.
            if (!long_done && results_seen >= 200) begin
                long_done  = 1'b1;
                stall_left = 300;
            end
            if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (results_seen >= 700 && results_seen < 850) begin
                rdy = 1'b1;
            end else if ($urandom_range(0, 99) < 25) begin
                stall_left = draw_gap();
                rdy = (stall_left == 0);
            end else begin
                rdy = 1'b1;
            end
            i_m_tready <= rdy;
        end
    end

    initial begin
        int   i;
        int   k;
        logic act;
        logic [IDX_W-1:0] idx;
        for (k = 0; k < 8; k++)
            key_pool[k] = KEY_W'({$urandom(), $urandom()} % 64'd10000000000000);

        // Reads of an empty table, then extreme and duplicate keys.
        add_req(skit_pkg::ACT_READ,   '0, '0, 6'd0, 1'b0, 1'b0);
        add_req(skit_pkg::ACT_READ,   '0, '0, 6'd63, 1'b0, 1'b0);
        add_req(skit_pkg::ACT_INSERT, 44'd5000, 12'd2000, 6'd0, 1'b0, 1'b0);
        add_req(skit_pkg::ACT_INSERT, '0, '0, 6'd0, 1'b0, 1'b0);
        add_req(skit_pkg::ACT_INSERT, KEY_TOP, 12'd4095, 6'd0, 1'b0, 1'b0);
        add_req(skit_pkg::ACT_INSERT, KEY_ONES, 12'd1, 6'd0, 1'b0, 1'b0);
        add_req(skit_pkg::ACT_INSERT, 44'd5000, 12'd1999, 6'd0, 1'b0, 1'b0);
        add_req(skit_pkg::ACT_INSERT, 44'd5000, 12'd7, 6'd0, 1'b0, 1'b0);
        add_req(skit_pkg::ACT_INSERT, 44'd1234567890123, 12'd2024, 6'd0, 1'b0, 1'b0);
        // Index 7 equals the count and must be flagged as out of range.
        for (k = 0; k < 8; k++)
            add_req(skit_pkg::ACT_READ, '0, '0, IDX_W'(k), 1'b0, 1'b0);
        add_req(skit_pkg::ACT_READ,   '0, '0, 6'd63, 1'b0, 1'b0);
        add_req(skit_pkg::ACT_READ,   KEY_ONES, 12'hFFF, 6'd42, 1'b0, 1'b0);
        add_req(skit_pkg::ACT_INSERT, '0, 12'd4095, 6'd63, 1'b0, 1'b0);
        add_req(skit_pkg::ACT_READ,   '0, '0, 6'd1, 1'b1, 1'b0);

        // Fill the table with reads mixed in, then keep reading and knocking on a full table.
        for (i = 0; i < N_RANDOM; i++) begin
            idx = IDX_W'($urandom_range(0, 63));
            if (plan_cnt >= TBL_DEPTH)
                act = ($urandom_range(0, 99) < 10) ? skit_pkg::ACT_INSERT
                                                   : skit_pkg::ACT_READ;
            else
                act = ($urandom_range(0, 99) < 16) ? skit_pkg::ACT_INSERT
                                                   : skit_pkg::ACT_READ;
            if (act == skit_pkg::ACT_READ && plan_cnt > 0 && $urandom_range(0, 99) < 85)
                idx = IDX_W'($urandom_range(0, plan_cnt - 1));
            add_req(act, draw_key(), YEAR_W'($urandom_range(0, 4095)), idx,
                    i == 700, i >= 900 && i < 1000);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pend_q.size() != 0 || exp_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0 && exp_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* filelist.f */
design/skit_pkg.sv
design/skit_cell.sv
design/sorted_key_insert_table_core.sv
dv/sorted_key_insert_table_core_tb.sv
